/* hw/rtl/tgr_pkg.sv */
// shared request codes and fixed field widths for the threshold graph reachability block
package tgr_pkg;

	localparam int REQ_W    = 2;
	localparam int VERTEX_W = 6;
	localparam int AMOUNT_W = 16;
	localparam int VCOUNT_W = 7;

	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

/* hw/rtl/threshold_graph_reachability.sv */
// threshold graph reachability: adjacency-row ram plus search sequencer
// clear drops the row valid bits; add edge does a read-modify-write of two rows (row a, then row b)
// query: one row read per visited vertex, until b is found or no vertex is pending;
//   an end out of range or a query to itself skips the search; a stalled result adds a wait
// throughput: one item at a time; a query is bound by one row read of the ram per vertex
// reset: async active low; vertex_count 64, row valid bits clear so the graph starts empty
module threshold_graph_reachability #(
	parameter int MAX_VERTICES = 64,
	parameter int CAP_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tgr_pkg::REQ_W-1:0]     req_type,
	input  logic [tgr_pkg::VERTEX_W-1:0]  vertex_a,
	input  logic [tgr_pkg::VERTEX_W-1:0]  vertex_b,
	input  logic [tgr_pkg::AMOUNT_W-1:0]  amount,
	// result item channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          path_found,
	// vertex_count register
	input  logic                          cfg_we,
	input  logic [tgr_pkg::VCOUNT_W-1:0]  cfg_wdata
);

	import tgr_pkg::*;

	// vertex index width
	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	// one adjacency entry: present bit in bit 0, capacity above it
	localparam int EW = CAP_BITS + 1;
	// one adjacency row holds an entry per destination vertex
	localparam int RW = MAX_VERTICES * EW;
	// width for vertex counts, enough for both the register and MAX_VERTICES
	localparam int NW = ($clog2(MAX_VERTICES + 1) > VCOUNT_W) ?
		$clog2(MAX_VERTICES + 1) : VCOUNT_W;
	// width for capacity vs width compare
	localparam int AW = (CAP_BITS > AMOUNT_W) ? CAP_BITS : AMOUNT_W;
	localparam logic [AW-1:0] CapMaxW = AW'({CAP_BITS{1'b1}});
	localparam logic [NW-1:0] MaxVertN = NW'(MAX_VERTICES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_Q_PICK,
		S_Q_EVAL,
		S_FINISH
	} state_t;

	state_t                 state_q;
	logic [VCOUNT_W-1:0]    vcount_q;
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] pending_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] mask_q;
	logic [VW-1:0]          a_q;
	logic [VW-1:0]          b_q;
	logic [CAP_BITS-1:0]    cap_q;
	logic [AMOUNT_W-1:0]    width_q;
	logic                   pass_q;
	logic                   found_q;
	logic                   rv_s1;
	logic                   out_valid_q;
	logic                   path_found_q;

	logic                   accept;
	logic [NW-1:0]          n_eff;
	logic                   a_ok;
	logic                   b_ok;
	logic [MAX_VERTICES-1:0] mask_n;
	logic [MAX_VERTICES-1:0] pend_init;
	logic [AW-1:0]          amount_w;
	logic [CAP_BITS-1:0]    cap_sat;
	logic [MAX_VERTICES-1:0] avail;
	logic                   any_avail;
	logic [VW-1:0]          pick;
	logic [VW-1:0]          raddr;
	logic [VW-1:0]          waddr;
	logic [VW-1:0]          col;
	logic                   we;
	logic [RW-1:0]          rdata;
	logic [RW-1:0]          row_eff;
	logic [RW-1:0]          wdata;
	logic [EW-1:0]          old_entry;
	logic [EW-1:0]          new_entry;
	logic [MAX_VERTICES-1:0] nb;
	logic [AW-1:0]          width_w;

	assign accept     = in_valid && in_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign path_found = path_found_q;

	// effective vertex count, vertices at or above it are out of play
	assign n_eff = (NW'(vcount_q) > MaxVertN) ? MaxVertN : NW'(vcount_q);
	assign a_ok  = NW'(vertex_a) < n_eff;
	assign b_ok  = NW'(vertex_b) < n_eff;

	always_comb begin
		for (int w = 0; w < MAX_VERTICES; w++) begin
			mask_n[w] = NW'(w) < n_eff;
		end
		pend_init = '0;
		pend_init[VW'(vertex_a)] = 1'b1;
	end

	// capacity saturates to the stored width
	assign amount_w = AW'(amount);
	assign cap_sat  = (amount_w > CapMaxW) ? CapMaxW[CAP_BITS-1:0] : amount_w[CAP_BITS-1:0];

	// lowest pending vertex that is still in range
	assign avail     = pending_q & mask_q;
	assign any_avail = |avail;
	always_comb begin
		pick = '0;
		for (int w = MAX_VERTICES - 1; w >= 0; w--) begin
			if (avail[w]) begin
				pick = VW'(w);
			end
		end
	end

	// ram addressing: add reads/writes row a then row b, query reads the picked row
	assign raddr = (state_q == S_ADD_RD) ? (pass_q ? b_q : a_q) : pick;
	assign waddr = pass_q ? b_q : a_q;
	assign col   = pass_q ? a_q : b_q;
	assign we    = (state_q == S_ADD_WR);

	// a row never written since the last clear reads as empty
	assign row_eff = rv_s1 ? rdata : '0;

	// edge update keeps the larger capacity
	always_comb begin
		old_entry = row_eff[col*EW +: EW];
		if (!old_entry[0] || (old_entry[EW-1:1] < cap_q)) begin
			new_entry = {cap_q, 1'b1};
		end else begin
			new_entry = old_entry;
		end
		wdata = row_eff;
		wdata[col*EW +: EW] = new_entry;
	end

	// neighbors of the visited row that pass the width and are new
	assign width_w = AW'(width_q);
	always_comb begin
		for (int w = 0; w < MAX_VERTICES; w++) begin
			nb[w] = row_eff[w*EW] && (AW'(row_eff[w*EW+1 +: CAP_BITS]) >= width_w) &&
				mask_q[w] && !visited_q[w];
		end
	end

	tgr_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vcount_q     <= VCOUNT_RESET;
			row_valid_q  <= '0;
			pending_q    <= '0;
			visited_q    <= '0;
			mask_q       <= '0;
			a_q          <= '0;
			b_q          <= '0;
			cap_q        <= '0;
			width_q      <= '0;
			pass_q       <= 1'b0;
			found_q      <= 1'b0;
			rv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
			path_found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_CLEAR: begin
								// dropping row valid bits empties the graph
								row_valid_q <= '0;
							end
							REQ_ADD: begin
								if (a_ok && b_ok) begin
									a_q     <= VW'(vertex_a);
									b_q     <= VW'(vertex_b);
									cap_q   <= cap_sat;
									pass_q  <= 1'b0;
									state_q <= S_ADD_RD;
								end
							end
							REQ_QUERY: begin
								a_q       <= VW'(vertex_a);
								b_q       <= VW'(vertex_b);
								width_q   <= amount;
								mask_q    <= mask_n;
								pending_q <= pend_init;
								visited_q <= '0;
								found_q   <= 1'b0;
								// out of range ends or a query to itself answer not found
								if (a_ok && b_ok && (vertex_a != vertex_b)) begin
									state_q <= S_Q_PICK;
								end else begin
									state_q <= S_FINISH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD_RD: begin
					rv_s1   <= row_valid_q[raddr];
					state_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					row_valid_q[waddr] <= 1'b1;
					if (!pass_q) begin
						// mirror entry goes into the other end's row
						pass_q  <= 1'b1;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_Q_PICK: begin
					if (!any_avail) begin
						found_q <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						pending_q[pick] <= 1'b0;
						visited_q[pick] <= 1'b1;
						rv_s1           <= row_valid_q[pick];
						state_q         <= S_Q_EVAL;
					end
				end
				S_Q_EVAL: begin
					if (nb[b_q]) begin
						found_q <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						pending_q <= pending_q | nb;
						state_q   <= S_Q_PICK;
					end
				end
				S_FINISH: begin
					// wait for the output register to free up
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						path_found_q <= found_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/tgr_ram.sv */
// generic single-write single-read ram with registered read data
module tgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/tgr_checker.sv */
// port-level checks for the threshold graph reachability block, with bind
module tgr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [tgr_pkg::REQ_W-1:0]     req_type,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          path_found
);

	import tgr_pkg::*;

	logic       q_acc;
	logic       o_acc;
	logic [1:0] open_q;

	assign q_acc = in_valid && in_ready && (req_type == REQ_QUERY);
	assign o_acc = out_valid && out_ready;

	// queries accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (q_acc && !o_acc) begin
			open_q <= open_q + 2'd1;
		end else if (o_acc && !q_acc && (open_q != 2'd0)) begin
			open_q <= open_q - 2'd1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(path_found))
		else $error("result changed while stalled");

	// every result belongs to an accepted query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (open_q != 2'd0))
		else $error("result without a query");

	// at most one answer waiting and one search in flight
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("too many open queries");

	// a query occupies the block for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> !in_ready)
		else $error("item accepted right after a query");

endmodule

bind threshold_graph_reachability tgr_checker u_tgr_checker (.*);
